/* hdl/p2r_pkg.sv */
`timescale 1ns / 1ps

package p2r_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int CODE_W         = 8;
    localparam int NUM_W          = SAMPLE_W + CODE_W;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = CODE_W / BITS_PER_STAGE;
    // numerator register, saturation check, then one register per divider stage
    localparam int LANE_LAT       = DIV_STAGES + 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int PLANE_IDX_W    = 2;
    localparam int COLOR_W        = 5;

    localparam logic [CODE_W-1:0] CODE_MAX  = 8'hff;
    localparam logic [CODE_W-1:0] HALF_CODE = 8'd128;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [CODE_W-1:0]   code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SAMPLE    = 3'd0,
        CFG_COLOR_MODE    = 3'd1,
        CFG_HAS_OPACITY   = 3'd2,
        CFG_OPACITY_PLANE = 3'd3,
        CFG_OPAQUE_CODE   = 3'd4
    } cfg_idx_t;

endpackage

/* hdl/p2r_scale.sv */
`timescale 1ns / 1ps

module p2r_scale (
    input  logic             clk,
    input  p2r_pkg::sample_t sample,
    input  p2r_pkg::sample_t divisor,
    output p2r_pkg::code_t   scaled
);
    import p2r_pkg::*;

    logic [NUM_W-1:0] num_next;
    logic [NUM_W-1:0] num_reg;
    logic             sat_next;
    logic [NUM_W-1:0] rem_reg [0:DIV_STAGES];
    code_t            q_reg   [0:DIV_STAGES];
    logic             sat_reg [0:DIV_STAGES];

    // s*255 + m/2, as (s << 8) - s
    always_comb
    begin
        num_next = {sample, {CODE_W{1'b0}}} - NUM_W'(sample) + NUM_W'(divisor >> 1);
    end

    // quotient above 255 whenever the numerator reaches 256*m
    always_comb
    begin
        sat_next = (num_reg >= {divisor, {CODE_W{1'b0}}});
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        rem_reg[0] <= num_reg;
        q_reg[0]   <= '0;
        sat_reg[0] <= sat_next;
    end

    // restoring division, BITS_PER_STAGE quotient bits per stage, MSB first
    for (genvar st = 0; st < DIV_STAGES; st++)
    begin : g_div
        logic [NUM_W-1:0] rem_next;
        code_t            q_next;

        always_comb
        begin
            logic [NUM_W-1:0] trial;
            int               k;
            rem_next = rem_reg[st];
            q_next   = q_reg[st];
            for (int j = 0; j < BITS_PER_STAGE; j++)
            begin
                k     = CODE_W - 1 - st * BITS_PER_STAGE - j;
                trial = NUM_W'(divisor) << k;
                if (rem_next >= trial)
                begin
                    rem_next  = rem_next - trial;
                    q_next[k] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[st+1] <= rem_next;
            q_reg[st+1]   <= q_next;
            sat_reg[st+1] <= sat_reg[st];
        end
    end

    assign scaled = sat_reg[DIV_STAGES] ? CODE_MAX : q_reg[DIV_STAGES];

endmodule

/* hdl/pixel_to_rgb555_alpha.sv */
`timescale 1ns / 1ps

// Pixel converter: one pixel of four 16-bit sample planes in, one RGB555 color
// word and one 8-bit alpha code out. A pixel transaction is taken at every
// rising edge with start high; busy is always low, so a new pixel may enter in
// every cycle. Each result appears on packed_color and alpha_code for exactly
// one cycle with done high, in order, after the pixel passes the select
// register (which loads at the edge that took it), a 6-stage rescaling
// divider and the output register. The receiver cannot stall: capture the
// result in the cycle done is high. Samples are rescaled to 0..255 as
// (s*255 + max/2)/max, saturating at 255; a max_sample of zero acts as one.
// Write configuration through cfg_we, cfg_index and cfg_data only while no
// pixel is in flight.

module pixel_to_rgb555_alpha (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  p2r_pkg::sample_t                    plane0,
    input  p2r_pkg::sample_t                    plane1,
    input  p2r_pkg::sample_t                    plane2,
    input  p2r_pkg::sample_t                    plane3,
    input  logic                                cfg_we,
    input  logic [p2r_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [p2r_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                done,
    output logic [15:0]                         packed_color,
    output p2r_pkg::code_t                      alpha_code
);
    import p2r_pkg::*;

    // configuration registers
    sample_t                max_sample_reg;
    logic                   color_mode_reg;
    logic                   has_opacity_reg;
    logic [PLANE_IDX_W-1:0] opacity_plane_reg;
    code_t                  opaque_code_reg;

    // effective divisor: zero acts as one
    sample_t                divisor;

    // select stage
    sample_t                red_next, green_next, blue_next, opac_next;
    sample_t                red_reg, green_reg, blue_reg, opac_reg;

    // valid bits, one per pipeline register in front of the output
    logic [LANE_LAT:0]      vld_reg;

    code_t                  red_scaled, green_scaled, blue_scaled, opac_scaled;

    logic [15:0]            color_next;
    code_t                  alpha_next;
    logic                   done_reg;
    logic [15:0]            color_reg;
    code_t                  alpha_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_sample_reg    <= SAMPLE_W'(255);
            color_mode_reg    <= 1'b1;
            has_opacity_reg   <= 1'b0;
            opacity_plane_reg <= PLANE_IDX_W'(3);
            opaque_code_reg   <= HALF_CODE;
        end
        else if (cfg_we)
        begin
            // drop writes to indexes past the register list
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAX_SAMPLE:    max_sample_reg    <= cfg_data[SAMPLE_W-1:0];
                CFG_COLOR_MODE:    color_mode_reg    <= cfg_data[0];
                CFG_HAS_OPACITY:   has_opacity_reg   <= cfg_data[0];
                CFG_OPACITY_PLANE: opacity_plane_reg <= cfg_data[PLANE_IDX_W-1:0];
                CFG_OPAQUE_CODE:   opaque_code_reg   <= cfg_data[CODE_W-1:0];
                default:           ;
            endcase
        end
    end

    assign divisor = (max_sample_reg == '0) ? SAMPLE_W'(1) : max_sample_reg;

    // Pick the four samples to scale. Gray mode routes plane 0 to all colors;
    // the opacity plane index is honored as given in either mode.
    always_comb
    begin
        red_next   = plane0;
        green_next = color_mode_reg ? plane1 : plane0;
        blue_next  = color_mode_reg ? plane2 : plane0;
        unique case (opacity_plane_reg)
            2'd0:    opac_next = plane0;
            2'd1:    opac_next = plane1;
            2'd2:    opac_next = plane2;
            default: opac_next = plane3;
        endcase
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        opac_reg  <= opac_next;
    end

    // Advance the valid bit alongside the data in every cycle; nothing stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LANE_LAT-1:0], start & ~busy};
        end
    end

    // Four identical rescaling lanes. The divider is exact for max 255 too,
    // so pass-through needs no separate path.
    p2r_scale u_scale_red (
        .clk     (clk),
        .sample  (red_reg),
        .divisor (divisor),
        .scaled  (red_scaled)
    );

    p2r_scale u_scale_green (
        .clk     (clk),
        .sample  (green_reg),
        .divisor (divisor),
        .scaled  (green_scaled)
    );

    p2r_scale u_scale_blue (
        .clk     (clk),
        .sample  (blue_reg),
        .divisor (divisor),
        .scaled  (blue_scaled)
    );

    p2r_scale u_scale_opac (
        .clk     (clk),
        .sample  (opac_reg),
        .divisor (divisor),
        .scaled  (opac_scaled)
    );

    // Pack the top five bits of each color; bit 5 stays zero.
    // Alpha: opaque code unless an opacity plane is enabled and below full scale.
    always_comb
    begin
        color_next = {red_scaled[CODE_W-1 -: COLOR_W], green_scaled[CODE_W-1 -: COLOR_W],
                      1'b0, blue_scaled[CODE_W-1 -: COLOR_W]};
        if (has_opacity_reg && (opac_scaled != CODE_MAX))
        begin
            alpha_next = HALF_CODE - (opac_scaled >> 1);
        end
        else
        begin
            alpha_next = opaque_code_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[LANE_LAT];
        end
    end

    // Hold the payload between results; load only with a finished transaction.
    always_ff @(posedge clk)
    begin
        if (vld_reg[LANE_LAT])
        begin
            color_reg <= color_next;
            alpha_reg <= alpha_next;
        end
    end

    assign done         = done_reg;
    assign packed_color = color_reg;
    assign alpha_code   = alpha_reg;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import p2r_pkg::*;

    typedef struct packed {
        logic [15:0] color;
        code_t       alpha;
    } pixel_out_t;

    class pixel_checker;
        logic [SAMPLE_W-1:0]    max_sample    = 16'd255;
        bit                     color_mode    = 1'b1;
        bit                     has_opacity   = 1'b0;
        logic [PLANE_IDX_W-1:0] opacity_plane = 2'd3;
        code_t                  opaque_code   = 8'd128;
        pixel_out_t             expected_pixels[$];
        int                     errors        = 0;

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAX_SAMPLE:    max_sample    = data;
                CFG_COLOR_MODE:    color_mode    = data[0];
                CFG_HAS_OPACITY:   has_opacity   = data[0];
                CFG_OPACITY_PLANE: opacity_plane = data[PLANE_IDX_W-1:0];
                CFG_OPAQUE_CODE:   opaque_code   = data[CODE_W-1:0];
                default: ;
            endcase
        endfunction

        // rescale to 0..255, saturating; zero max acts as one
        function code_t rescale(sample_t s);
            int unsigned m;
            int unsigned v;
            m = (max_sample == 0) ? 1 : 32'(max_sample);
            if (m == 255)
                v = 32'(s);
            else
                v = (32'(s) * 255 + m / 2) / m;
            return (v > 255) ? CODE_MAX : v[CODE_W-1:0];
        endfunction

        function void note_pixel(sample_t p0, sample_t p1, sample_t p2, sample_t p3);
            sample_t    planes[4];
            code_t      r, g, b, a;
            pixel_out_t e;
            planes[0] = p0;
            planes[1] = p1;
            planes[2] = p2;
            planes[3] = p3;
            r = rescale(p0);
            if (color_mode)
            begin
                g = rescale(p1);
                b = rescale(p2);
            end
            else
            begin
                g = r;
                b = r;
            end
            e.color = {r[7:3], g[7:3], 1'b0, b[7:3]};
            if (has_opacity)
            begin
                a = rescale(planes[opacity_plane]);
                e.alpha = (a == CODE_MAX) ? opaque_code : HALF_CODE - {1'b0, a[7:1]};
            end
            else
                e.alpha = opaque_code;
            expected_pixels.push_back(e);
        endfunction

        function void check_result(logic [15:0] color, code_t alpha);
            pixel_out_t e;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result color %h alpha %h", $time, color, alpha);
                return;
            end
            e = expected_pixels.pop_front();
            if (color !== e.color)
            begin
                errors++;
                $display("%0t: packed_color expected %h, got %h", $time, e.color, color);
            end
            if (alpha !== e.alpha)
            begin
                errors++;
                $display("%0t: alpha_code expected %h, got %h", $time, e.alpha, alpha);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    sample_t               plane0    = '0;
    sample_t               plane1    = '0;
    sample_t               plane2    = '0;
    sample_t               plane3    = '0;
    logic                  cfg_we    = 1'b0;
    cfg_idx_t              cfg_index = CFG_MAX_SAMPLE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  done;
    logic [15:0]           packed_color;
    code_t                 alpha_code;

    pixel_checker scoreboard;
    // idle odds: 0 means back-to-back pixels, n means one gap in about n pixels
    int unsigned  idle_odds;

    pixel_to_rgb555_alpha u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .plane0       (plane0),
        .plane1       (plane1),
        .plane2       (plane2),
        .plane3       (plane3),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .packed_color (packed_color),
        .alpha_code   (alpha_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block never answers.
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Capture every result in its strobe cycle; the receiver cannot stall,
    // so sample the outputs as they stand just before the closing edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
            scoreboard.check_result(packed_color, alpha_code);
    end

    // Write one register; hold cfg_we high so back-to-back writes need no drop.
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        scoreboard.set_reg(idx, data);
    endtask

    // Write the whole register set, then drop the write enable.
    task automatic set_config(logic [15:0] max_s, bit color, bit opac,
                              logic [1:0] plane, code_t opaque);
        write_reg(CFG_MAX_SAMPLE, max_s);
        write_reg(CFG_COLOR_MODE, {15'd0, color});
        write_reg(CFG_HAS_OPACITY, {15'd0, opac});
        write_reg(CFG_OPACITY_PLANE, {14'd0, plane});
        write_reg(CFG_OPAQUE_CODE, {8'd0, opaque});
        cfg_we <= 1'b0;
    endtask

    // Present one pixel and hold it until the transaction is taken.
    // busy is read as it stood before the edge, so the check is race free.
    task automatic send_pixel(sample_t p0, sample_t p1, sample_t p2, sample_t p3);
        start  <= 1'b1;
        plane0 <= p0;
        plane1 <= p1;
        plane2 <= p2;
        plane3 <= p3;
        @(posedge clk iff !busy);
        scoreboard.note_pixel(p0, p1, p2, p3);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            // idle the source for a random burst; scramble plane 0 while idle
            start  <= 1'b0;
            plane0 <= 16'($urandom_range(0, 65535));
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Drop start and wait for every outstanding result before touching config.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (scoreboard.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly in-range samples; the rest hit the ends or overshoot the max.
    function automatic sample_t rand_sample(sample_t max_s);
        int unsigned m;
        m = (max_s == '0) ? 1 : 32'(max_s);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return sample_t'(m);
            2: return (m < 65535) ? sample_t'($urandom_range(m + 1, 65535)) : 16'hffff;
            3: return sample_t'($urandom_range(0, 65535));
            4: return sample_t'(m - 1);
            default: return sample_t'($urandom_range(0, m));
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [15:0] max_s;
        case ($urandom_range(0, 7))
            0: max_s = 16'd0;
            1: max_s = 16'd1;
            2: max_s = 16'd255;
            3: max_s = 16'hffff;
            4: max_s = 16'($urandom_range(2, 300));
            5: max_s = 16'((1 << $urandom_range(2, 16)) - 1);
            default: max_s = 16'($urandom_range(1, 65535));
        endcase
        set_config(max_s, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        repeat (count)
            send_pixel(rand_sample(max_s), rand_sample(max_s),
                       rand_sample(max_s), rand_sample(max_s));
        drain();
    endtask

    initial
    begin
        scoreboard = new();
        idle_odds  = 3;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: pass-through at max 255, saturation above it.
        send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'd255, 16'd255, 16'd255, 16'd255);
        send_pixel(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_pixel(16'd256, 16'd128, 16'd7, 16'd8);
        drain();

        // Opacity in plane 3: opaque at full scale, else 128 minus half.
        set_config(16'd255, 1'b1, 1'b1, 2'd3, 8'hff);
        send_pixel(16'd10, 16'd20, 16'd30, 16'd255);
        send_pixel(16'd10, 16'd20, 16'd30, 16'd0);
        send_pixel(16'd10, 16'd20, 16'd30, 16'd254);
        send_pixel(16'd10, 16'd20, 16'd30, 16'd300);
        drain();

        // Zero max acts as one; gray mode with opacity from plane 0.
        set_config(16'd0, 1'b0, 1'b1, 2'd0, 8'h00);
        send_pixel(16'd0, 16'hffff, 16'h1234, 16'h0);
        send_pixel(16'd1, 16'd0, 16'd0, 16'd0);
        send_pixel(16'hffff, 16'd0, 16'hffff, 16'hffff);
        drain();

        // Widest max: exercise rounding at the top and middle of the range.
        set_config(16'hffff, 1'b1, 1'b1, 2'd1, 8'd77);
        send_pixel(16'hffff, 16'hffff, 16'h8000, 16'h0);
        send_pixel(16'h8000, 16'h0080, 16'h0001, 16'hffff);
        send_pixel(16'h0000, 16'hfffe, 16'h7fff, 16'h0101);
        drain();

        // Max one in gray mode, opacity plane 2.
        set_config(16'd1, 1'b0, 1'b1, 2'd2, 8'd200);
        send_pixel(16'd0, 16'd0, 16'd1, 16'd0);
        send_pixel(16'd1, 16'd1, 16'd0, 16'd1);
        send_pixel(16'd2, 16'd0, 16'd5, 16'd0);
        drain();

        // Odd max, no opacity plane.
        set_config(16'd1000, 1'b1, 1'b0, 2'd0, 8'h80);
        send_pixel(16'd500, 16'd999, 16'd1000, 16'd0);
        send_pixel(16'd2, 16'd1001, 16'd3, 16'hffff);
        drain();

        // Random phases with varying source gaps; the last runs back to back.
        for (int phase = 0; phase < 12; phase++)
        begin
            case ($urandom_range(0, 2))
                0: idle_odds = 0;
                1: idle_odds = 3;
                default: idle_odds = 8;
            endcase
            if (phase == 11)
                idle_odds = 0;
            random_phase(75);
        end

        // Let any stray strobe show up before closing the run.
        repeat (LANE_LAT + 8) @(posedge clk);
        if (scoreboard.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* pixel_to_rgb555_alpha.f */
hdl/p2r_pkg.sv
hdl/p2r_scale.sv
hdl/pixel_to_rgb555_alpha.sv
sim/testbench.sv
